>>> hw/rtl/mm3_pkg.sv
// mm3_pkg: shared types and constants for the murmur3-32 stream hash unit
// used by mm3_cfg, mm3_ctrl, mm3_dp and the top level; no dependencies
`timescale 1ns / 1ps

package mm3_pkg;

  localparam logic [31:0] SEED_RESET = 32'hFEED_FACE;
  localparam logic [31:0] MIX_C1     = 32'hcc9e_2d51;
  localparam logic [31:0] MIX_C2     = 32'h1b87_3593;
  localparam logic [31:0] MIX_N1     = 32'he654_6b64;
  localparam logic [31:0] FIN_F1     = 32'h85eb_ca6b;
  localparam logic [31:0] FIN_F2     = 32'hc2b2_ae35;

  // configuration register indexes
  localparam logic REG_SEED = 1'b0;
  localparam logic REG_MODE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY2,
    ST_UPDATE,
    ST_FIN1,
    ST_FIN2,
    ST_EMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_item;
    logic key_mix2;
    logic update;
    logic fin1;
    logic fin2;
    logic emit;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full_word;
    logic empty_tail;
    logic last_word;
  } dp_status_t;

endpackage

>>> hw/rtl/mm3_cfg.sv
// mm3_cfg: apb-style configuration registers (seed, word count mode)
// depends on mm3_pkg
`timescale 1ns / 1ps

module mm3_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic [31:0] seed,
  output logic        word_count_mode,
  output logic        seed_wr
);

  logic [31:0] seed_r, seed_nxt;
  logic        mode_r, mode_nxt;
  logic        wr_en;
  logic        reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2];
  assign seed_wr = wr_en & (reg_idx == mm3_pkg::REG_SEED);

  always_comb begin
    seed_nxt = seed_r;
    mode_nxt = mode_r;
    if (wr_en) begin
      unique case (reg_idx)
        mm3_pkg::REG_SEED: seed_nxt = pwdata;
        mm3_pkg::REG_MODE: mode_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= mm3_pkg::SEED_RESET;
      mode_r <= 1'b0;
    end else begin
      seed_r <= seed_nxt;
      mode_r <= mode_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      mm3_pkg::REG_SEED: prdata = seed_r;
      mm3_pkg::REG_MODE: prdata = {31'd0, mode_r};
      default:           prdata = 32'd0;
    endcase
  end

  // seed in force after this edge, so a seed write reloads the hash with the new value
  assign seed            = seed_nxt;
  assign word_count_mode = mode_r;

endmodule

>>> hw/rtl/mm3_ctrl.sv
// mm3_ctrl: sequencing state machine for the murmur3-32 stream hash unit
// depends on mm3_pkg; drives commands into mm3_dp
`timescale 1ns / 1ps

module mm3_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  mm3_pkg::dp_status_t status,
  output mm3_pkg::dp_cmd_t    cmd
);

  mm3_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  assign slot_free = ~out_valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mm3_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      mm3_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = mm3_pkg::ST_KEY2;
        end
      end
      mm3_pkg::ST_KEY2: begin
        // empty tail goes straight to finalization
        if (status.empty_tail) begin
          state_nxt = mm3_pkg::ST_FIN1;
        end else begin
          cmd.key_mix2 = 1'b1;
          state_nxt    = mm3_pkg::ST_UPDATE;
        end
      end
      mm3_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        if (status.full_word && !status.last_word) state_nxt = mm3_pkg::ST_IDLE;
        else                                       state_nxt = mm3_pkg::ST_FIN1;
      end
      mm3_pkg::ST_FIN1: begin
        cmd.fin1  = 1'b1;
        state_nxt = mm3_pkg::ST_FIN2;
      end
      mm3_pkg::ST_FIN2: begin
        cmd.fin2  = 1'b1;
        state_nxt = mm3_pkg::ST_EMIT;
      end
      mm3_pkg::ST_EMIT: begin
        // hold until the output register is free
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = mm3_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mm3_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/mm3_dp.sv
// mm3_dp: murmur3-32 datapath with one shared 32x32 multiplier
// depends on mm3_pkg; commanded by mm3_ctrl
`timescale 1ns / 1ps

module mm3_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  mm3_pkg::dp_cmd_t    cmd,
  output mm3_pkg::dp_status_t status,
  input  logic [31:0]         in_data_word,
  input  logic [2:0]          in_byte_count,
  input  logic                in_last_word,
  input  logic [31:0]         seed,
  input  logic                word_count_mode,
  input  logic                seed_wr,
  output logic [31:0]         hash_value
);

  logic [31:0] hash_r, hash_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] fin_r, fin_nxt;
  logic [31:0] out_r, out_nxt;
  logic [2:0]  bc_r, bc_nxt;
  logic        last_r, last_nxt;

  logic [31:0] mul_a, mul_b, mul_p;
  logic [31:0] in_masked;
  logic [31:0] mixed, rot13, fin_in;
  logic        full_word;

  // full word for counts of four and above
  assign full_word = bc_r[2];

  always_comb begin
    unique case (in_byte_count)
      3'd1:    in_masked = {24'd0, in_data_word[7:0]};
      3'd2:    in_masked = {16'd0, in_data_word[15:0]};
      3'd3:    in_masked = {8'd0, in_data_word[23:0]};
      3'd0:    in_masked = 32'd0;
      default: in_masked = in_data_word;
    endcase
  end

  assign mixed  = hash_r ^ key_r;
  assign rot13  = {mixed[18:0], mixed[31:19]};
  assign fin_in = (word_count_mode && len_r[1:0] == 2'b00) ?
                  (hash_r ^ {2'b00, len_r[31:2]}) : (hash_r ^ len_r);

  // shared multiplier, operands chosen by the active command
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    priority if (cmd.load_item) begin
      mul_a = in_masked;
      mul_b = mm3_pkg::MIX_C1;
    end else if (cmd.key_mix2) begin
      mul_a = {key_r[16:0], key_r[31:17]};
      mul_b = mm3_pkg::MIX_C2;
    end else if (cmd.fin1) begin
      mul_a = fin_in ^ {16'd0, fin_in[31:16]};
      mul_b = mm3_pkg::FIN_F1;
    end else if (cmd.fin2) begin
      mul_a = fin_r ^ {13'd0, fin_r[31:13]};
      mul_b = mm3_pkg::FIN_F2;
    end else begin
      mul_a = 32'd0;
    end
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    hash_nxt = hash_r;
    len_nxt  = len_r;
    key_nxt  = key_r;
    fin_nxt  = fin_r;
    out_nxt  = out_r;
    bc_nxt   = bc_r;
    last_nxt = last_r;
    if (cmd.load_item) begin
      key_nxt  = mul_p;
      bc_nxt   = in_byte_count;
      last_nxt = in_last_word;
    end
    if (cmd.key_mix2) key_nxt = mul_p;
    if (cmd.update) begin
      if (full_word) begin
        hash_nxt = {rot13[29:0], 2'b00} + rot13 + mm3_pkg::MIX_N1;
        len_nxt  = len_r + 32'd4;
      end else begin
        hash_nxt = mixed;
        len_nxt  = len_r + {30'd0, bc_r[1:0]};
      end
    end
    if (cmd.fin1 || cmd.fin2) fin_nxt = mul_p;
    if (cmd.emit) begin
      out_nxt = fin_r ^ {16'd0, fin_r[31:16]};
    end
    // new message starts from the seed
    if (cmd.emit || seed_wr) begin
      hash_nxt = seed;
      len_nxt  = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= mm3_pkg::SEED_RESET;
      len_r  <= 32'd0;
    end else begin
      hash_r <= hash_nxt;
      len_r  <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    fin_r  <= fin_nxt;
    out_r  <= out_nxt;
    bc_r   <= bc_nxt;
    last_r <= last_nxt;
  end

  assign status.full_word  = full_word;
  assign status.empty_tail = (bc_r == 3'd0);
  assign status.last_word  = last_r;
  assign hash_value        = out_r;

endmodule

>>> hw/rtl/murmur3_32_stream_hash_unit.sv
// murmur3_32_stream_hash_unit: top level of the streaming murmur3-32 hasher
// depends on mm3_pkg, mm3_cfg, mm3_ctrl and mm3_dp
`timescale 1ns / 1ps

// usage:
//   in_*  : one little-endian message word per transaction with its byte
//           count (0..4, above 4 counts as 4) and a last-word flag; a count
//           below 4 always ends the message
//   out_* : one finalized 32-bit hash per completed message
//   cfg_* : apb-style port, seed at 0x0, word count mode at 0x4; writing the
//           seed restarts the running hash and length from the new seed
// the single shared multiplier runs the two key-mix and two finalizer
// products one after another, so message words are taken one at a time:
//   full non-final word  : key mix and update, then the next acceptance
//   final word           : key mix, update, finalizer and emit (which waits
//                          for a free output register), then the next word
//   empty tail           : finalizer and emit, skipping second key mix and update
// a finished hash waits in the output register while the next message
// already streams in; only a second hash waits for out_ready to free it
// reset loads the seed with 0xfeedface, clears the mode and the length,
// and leaves the output channel empty

module murmur3_32_stream_hash_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hash_value,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  mm3_pkg::dp_cmd_t    cmd;
  mm3_pkg::dp_status_t status;
  logic [31:0]         seed;
  logic                word_count_mode;
  logic                seed_wr;

  assign cfg_pready = 1'b1;

  mm3_cfg u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (cfg_psel),
    .penable         (cfg_penable),
    .pwrite          (cfg_pwrite),
    .paddr           (cfg_paddr),
    .pwdata          (cfg_pwdata),
    .prdata          (cfg_prdata),
    .seed            (seed),
    .word_count_mode (word_count_mode),
    .seed_wr         (seed_wr)
  );

  mm3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mm3_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_data_word    (in_data_word),
    .in_byte_count   (in_byte_count),
    .in_last_word    (in_last_word),
    .seed            (seed),
    .word_count_mode (word_count_mode),
    .seed_wr         (seed_wr),
    .hash_value      (out_hash_value)
  );

endmodule
